[sv/tkr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkr_pkg
// Types, constants and the divider step shared by the touch/key report
// frame encoder.
// ----------------------------------------------------------------------------
package tkr_pkg;

    // Event opcodes.
    localparam logic [1:0] OP_CONTACT = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MAKE    = 2'd2;
    localparam logic [1:0] OP_BREAK   = 2'd3;

    // Frame header bytes.
    localparam logic [7:0] HDR_CONTACT = 8'hBF;
    localparam logic [7:0] HDR_RELEASE = 8'hDF;
    localparam logic [7:0] HDR_MAKE    = 8'hFA;
    localparam logic [7:0] HDR_BREAK   = 8'hF0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_CAL_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_CAL_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_HIGH     = 3'd5;

    localparam int CFG_DATA_W = 16;
    localparam int SPAN_W     = 12;
    localparam int CAL_W      = 16;
    localparam int PIX_W      = 16;
    localparam int C14_W      = 14;
    localparam int HALF_W     = 7;

    // Reset values of the configuration registers.
    localparam logic [SPAN_W-1:0] RST_SURFACE_WIDTH  = 12'd640;
    localparam logic [SPAN_W-1:0] RST_SURFACE_HEIGHT = 12'd480;
    localparam logic [CAL_W-1:0]  RST_X_CAL_LOW      = 16'h6F40;
    localparam logic [CAL_W-1:0]  RST_X_CAL_HIGH     = 16'h11C0;
    localparam logic [CAL_W-1:0]  RST_Y_CAL_LOW      = 16'h6AC0;
    localparam logic [CAL_W-1:0]  RST_Y_CAL_HIGH     = 16'h1660;

    // Mapping constants.
    localparam logic signed [16:0] NORM_OFFSET  = 17'sd3276;
    localparam logic [15:0]        NORM_DIVISOR = 16'd26214;
    localparam logic [16:0]        C14_MAX      = 17'h3FFF;

    // Divider: four quotient bits per cycle.
    localparam int REM_W         = 15;
    localparam int DIVA_W        = 20;
    localparam int RADIX_STEPS   = 4;
    localparam int DIV1_Q_BITS   = 16;
    localparam int DIV1_CYCLES   = DIV1_Q_BITS / RADIX_STEPS;
    localparam int DIV2_CYCLES   = DIVA_W / RADIX_STEPS;
    localparam int CNT_W         = 3;

    // Byte positions in a frame.
    localparam logic [2:0] BYTE_HEADER = 3'd0;
    localparam logic [2:0] BYTE_X_HI   = 3'd1;
    localparam logic [2:0] BYTE_X_LO   = 3'd2;
    localparam logic [2:0] BYTE_Y_HI   = 3'd3;
    localparam logic [2:0] BYTE_Y_LO   = 3'd4;
    localparam logic [2:0] BYTE_SCAN   = 3'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Per-axis work for the mapping unit.
    typedef struct packed {
        logic [SPAN_W-1:0] p;       // clamped pixel
        logic [SPAN_W-1:0] sm1;     // span minus one, at least one
        logic [CAL_W-1:0]  cal_lo;
        logic [CAL_W:0]    diff;    // cal_high - cal_low, two's complement
    } axis_cmd_t;

    typedef struct packed {
        logic       is_touch;
        logic [7:0] header;
        logic [7:0] scancode;
        axis_cmd_t  x;
        axis_cmd_t  y;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic ack;
    } axis_ctl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } axis_sts_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIVA_W-1:0] a;
    } div_state_t;

    // One restoring division step: shift in the next dividend bit, subtract
    // when possible and shift the quotient bit in at the bottom.
    function automatic div_state_t div_step(div_state_t s, logic [REM_W:0] dv);
        logic [REM_W:0] r2;
        div_state_t     o;
        r2 = {s.rem, s.a[DIVA_W-1]};
        if (r2 >= dv) begin
            o.rem = REM_W'(r2 - dv);
            o.a   = {s.a[DIVA_W-2:0], 1'b1};
        end else begin
            o.rem = r2[REM_W-1:0];
            o.a   = {s.a[DIVA_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

[sv/touch_key_report_frame_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_key_report_frame_encoder
// Turns pen and key events into serial report frames: five bytes for a touch
// item, two bytes for a key item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// event     in         push / full            opcode, pixel_x, pixel_y, scancode
// frame     out        empty / pop            frame_byte, last_byte
// config    in         cfg_write (no stall)   cfg_index, cfg_data
//
// A key item leaves as two bytes, one per pop. A touch item runs through the
// two axis mappers (radix-16 divider: span division, multiply, load, then
// calibration division and clamp); its five bytes drain while the next item
// is mapped.
// Reset restores the configuration defaults and empties queue and frame register.
// A stalled result output never blocks intake until the two-entry command
// queue fills.
// ----------------------------------------------------------------------------
module touch_key_report_frame_encoder
    import tkr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic signed [PIX_W-1:0] pixel_x,
    input  logic signed [PIX_W-1:0] pixel_y,
    input  logic [7:0]              scancode,
    output logic                    empty,
    input  logic                    pop,
    output logic [7:0]              frame_byte,
    output logic                    last_byte
);

    logic q_full;
    logic q_empty;
    logic q_write;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    tkr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .scancode  (scancode),
        .q_full    (q_full),
        .q_write   (q_write),
        .q_cmd     (q_cmd)
    );

    tkr_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_write),
        .wdata (q_cmd),
        .rd    (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .rdata (q_head)
    );

    tkr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

[sv/tkr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkr_front
// Configuration registers and event intake: classifies each item, clamps the
// pixels against the surface span and writes a command into the queue.
// ----------------------------------------------------------------------------
module tkr_front
    import tkr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic signed [PIX_W-1:0] pixel_x,
    input  logic signed [PIX_W-1:0] pixel_y,
    input  logic [7:0]              scancode,
    input  logic                    q_full,
    output logic                    q_write,
    output cmd_t                    q_cmd
);

    logic [SPAN_W-1:0] surface_width_reg;
    logic [SPAN_W-1:0] surface_height_reg;
    logic [CAL_W-1:0]  x_cal_low_reg;
    logic [CAL_W-1:0]  x_cal_high_reg;
    logic [CAL_W-1:0]  y_cal_low_reg;
    logic [CAL_W-1:0]  y_cal_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= RST_SURFACE_WIDTH;
            surface_height_reg <= RST_SURFACE_HEIGHT;
            x_cal_low_reg      <= RST_X_CAL_LOW;
            x_cal_high_reg     <= RST_X_CAL_HIGH;
            y_cal_low_reg      <= RST_Y_CAL_LOW;
            y_cal_high_reg     <= RST_Y_CAL_HIGH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data[SPAN_W-1:0];
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_data[SPAN_W-1:0];
                REG_X_CAL_LOW:      x_cal_low_reg      <= cfg_data;
                REG_X_CAL_HIGH:     x_cal_high_reg     <= cfg_data;
                REG_Y_CAL_LOW:      y_cal_low_reg      <= cfg_data;
                REG_Y_CAL_HIGH:     y_cal_high_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Spans below two act as two; the pixel is held to 0..span-1.
    function automatic axis_cmd_t make_axis(logic signed [PIX_W-1:0] pix,
                                            logic [SPAN_W-1:0] span,
                                            logic [CAL_W-1:0] lo,
                                            logic [CAL_W-1:0] hi);
        axis_cmd_t c;
        c.sm1 = (span < SPAN_W'(2)) ? SPAN_W'(1) : SPAN_W'(span - SPAN_W'(1));
        if (pix[PIX_W-1])
            c.p = '0;
        else if (pix[PIX_W-2:0] > (PIX_W-1)'(c.sm1))
            c.p = c.sm1;
        else
            c.p = pix[SPAN_W-1:0];
        c.cal_lo = lo;
        c.diff   = {1'b0, hi} - {1'b0, lo};
        return c;
    endfunction

    always_comb
    begin
        q_cmd.is_touch = (opcode == OP_CONTACT) || (opcode == OP_RELEASE);
        case (opcode)
            OP_CONTACT: q_cmd.header = HDR_CONTACT;
            OP_RELEASE: q_cmd.header = HDR_RELEASE;
            OP_MAKE:    q_cmd.header = HDR_MAKE;
            OP_BREAK:   q_cmd.header = HDR_BREAK;
            default:    q_cmd.header = HDR_BREAK;
        endcase
        q_cmd.scancode = scancode;
        q_cmd.x = make_axis(pixel_x, surface_width_reg, x_cal_low_reg, x_cal_high_reg);
        q_cmd.y = make_axis(pixel_y, surface_height_reg, y_cal_low_reg, y_cal_high_reg);
    end

    assign full    = q_full;
    assign q_write = push && !q_full;

endmodule

[sv/tkr_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkr_cmd_queue
// Short command queue between the intake and the mapping/serializing back end.
// ----------------------------------------------------------------------------
module tkr_cmd_queue
    import tkr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    input  logic rd,
    output logic full,
    output logic empty,
    output cmd_t rdata
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[sv/tkr_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkr_axis
// Maps one clamped pixel to a 14-bit raw panel value with a shared radix-16
// restoring divider, one multiply and a final saturation.
// ----------------------------------------------------------------------------
module tkr_axis
    import tkr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  axis_ctl_t        ctl,
    input  axis_cmd_t        cmd,
    output axis_sts_t        sts,
    output logic [C14_W-1:0] c14
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV1  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_LOAD2 = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              load;

    logic [REM_W-1:0]  rem_reg;
    logic [DIVA_W-1:0] a_reg;
    logic [SPAN_W-1:0] sm1_reg;
    logic [CAL_W-1:0]  cal_lo_reg;
    logic [CAL_W:0]    diff_reg;
    logic signed [31:0] prod_reg;
    logic              neg_reg;
    logic [C14_W-1:0]  c14_reg;

    div_state_t        ds;
    logic [REM_W:0]    dv;
    logic signed [16:0] nm;
    logic signed [33:0] prod_full;
    logic [31:0]       mag;
    logic signed [20:0] sq;
    logic signed [20:0] raw8;
    logic [16:0]       c_div8;
    logic [C14_W-1:0]  c14_sat;

    assign sts.done  = (state_reg == S_DONE);
    assign sts.ready = (state_reg == S_IDLE) || (sts.done && ctl.ack);
    assign load      = sts.ready && ctl.start;
    assign c14       = c14_reg;

    always_comb
    begin
        dv = (state_reg == S_DIV1) ? (REM_W+1)'(sm1_reg) : NORM_DIVISOR;
        ds.rem = rem_reg;
        ds.a   = a_reg;
        for (int i = 0; i < RADIX_STEPS; i++)
            ds = div_step(ds, dv);

        nm        = $signed({1'b0, a_reg[DIV1_Q_BITS-1:0]}) - NORM_OFFSET;
        prod_full = 34'(nm) * 34'($signed(diff_reg));
        mag       = prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg);

        // Quotient toward zero, then raw8/8; negative raw values end at zero.
        sq     = neg_reg ? -$signed({1'b0, a_reg}) : $signed({1'b0, a_reg});
        raw8   = $signed({5'b0, cal_lo_reg}) + sq;
        c_div8 = raw8[19:3];
        if (raw8[20])
            c14_sat = '0;
        else if (c_div8 > C14_MAX)
            c14_sat = C14_MAX[C14_W-1:0];
        else
            c14_sat = c_div8[C14_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
                if (ctl.start)
                    state_next = S_DIV1;
            S_DIV1:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV1_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_LOAD2;
            S_LOAD2: state_next = S_DIV2;
            S_DIV2:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV2_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FIX;
                end
            end
            S_FIX:   state_next = S_DONE;
            S_DONE:
                if (ctl.ack)
                    state_next = ctl.start ? S_DIV1 : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // Dividend is p*32768; its top part p>>1 is already below span-1.
            rem_reg    <= REM_W'(cmd.p[SPAN_W-1:1]);
            a_reg      <= {cmd.p[0], {(DIVA_W-1){1'b0}}};
            sm1_reg    <= cmd.sm1;
            cal_lo_reg <= cmd.cal_lo;
            diff_reg   <= cmd.diff;
        end
        else
        begin
            case (state_reg)
                S_DIV1, S_DIV2:
                begin
                    rem_reg <= ds.rem;
                    a_reg   <= ds.a;
                end
                S_MUL:
                    prod_reg <= prod_full[31:0];
                S_LOAD2:
                begin
                    neg_reg <= prod_reg[31];
                    rem_reg <= REM_W'(mag[31:DIVA_W]);
                    a_reg   <= mag[DIVA_W-1:0];
                end
                S_FIX:
                    c14_reg <= c14_sat;
                default: ;
            endcase
        end
    end

endmodule

[sv/tkr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkr_back
// Takes commands from the queue, runs both axis mappers for touch items and
// serializes each frame one byte at a time from the frame register.
// ----------------------------------------------------------------------------
module tkr_back
    import tkr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] frame_byte,
    output logic       last_byte
);

    axis_ctl_t         axis_ctl;
    axis_sts_t         x_sts;
    axis_sts_t         y_sts;
    logic [C14_W-1:0]  x_c14;
    logic [C14_W-1:0]  y_c14;

    logic              slot_valid_reg;
    logic              slot_touch_reg;
    logic [7:0]        slot_header_reg;
    logic [7:0]        slot_scan_reg;

    logic              frame_valid_reg;
    logic              frame_touch_reg;
    logic [7:0]        frame_header_reg;
    logic [7:0]        frame_scan_reg;
    logic [C14_W-1:0]  frame_x_reg;
    logic [C14_W-1:0]  frame_y_reg;
    logic [2:0]        idx_reg;

    logic              pop_out;
    logic              frame_free;
    logic              slot_ready;
    logic              slot_move;
    logic              slot_free;

    tkr_axis u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (axis_ctl),
        .cmd   (q_head.x),
        .sts   (x_sts),
        .c14   (x_c14)
    );

    tkr_axis u_axis_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (axis_ctl),
        .cmd   (q_head.y),
        .sts   (y_sts),
        .c14   (y_c14)
    );

    assign empty      = !frame_valid_reg;
    assign last_byte  = frame_touch_reg ? (idx_reg == BYTE_Y_LO) : (idx_reg == BYTE_SCAN);
    assign pop_out    = pop && frame_valid_reg;
    assign frame_free = !frame_valid_reg || (pop_out && last_byte);
    assign slot_ready = slot_valid_reg && (!slot_touch_reg || (x_sts.done && y_sts.done));
    assign slot_move  = slot_ready && frame_free;
    assign slot_free  = !slot_valid_reg || slot_move;

    // A touch command may only leave the queue when both mappers can start.
    assign axis_ctl.ack   = slot_move && slot_touch_reg;
    assign q_pop          = !q_empty && slot_free
                            && (!q_head.is_touch || (x_sts.ready && y_sts.ready));
    assign axis_ctl.start = q_pop && q_head.is_touch;

    always_comb
    begin
        case (idx_reg)
            BYTE_HEADER: frame_byte = frame_header_reg;
            BYTE_X_HI:   frame_byte = frame_touch_reg ? {1'b0, frame_x_reg[C14_W-1:HALF_W]}
                                                      : frame_scan_reg;
            BYTE_X_LO:   frame_byte = {1'b0, frame_x_reg[HALF_W-1:0]};
            BYTE_Y_HI:   frame_byte = {1'b0, frame_y_reg[C14_W-1:HALF_W]};
            BYTE_Y_LO:   frame_byte = {1'b0, frame_y_reg[HALF_W-1:0]};
            default:     frame_byte = frame_header_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= 1'b0;
            frame_valid_reg <= 1'b0;
            idx_reg         <= BYTE_HEADER;
        end
        else
        begin
            if (q_pop)
                slot_valid_reg <= 1'b1;
            else if (slot_move)
                slot_valid_reg <= 1'b0;

            if (slot_move)
            begin
                frame_valid_reg <= 1'b1;
                idx_reg         <= BYTE_HEADER;
            end
            else if (pop_out)
            begin
                if (last_byte)
                    frame_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            slot_touch_reg  <= q_head.is_touch;
            slot_header_reg <= q_head.header;
            slot_scan_reg   <= q_head.scancode;
        end
        if (slot_move)
        begin
            frame_touch_reg  <= slot_touch_reg;
            frame_header_reg <= slot_header_reg;
            frame_scan_reg   <= slot_scan_reg;
            frame_x_reg      <= x_c14;
            frame_y_reg      <= y_c14;
        end
    end

`ifndef NO_ASSERTIONS
    a_axes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (x_sts.done == y_sts.done) && (x_sts.ready == y_sts.ready))
        else $error("axis mappers out of step");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        axis_ctl.start |=> !x_sts.done && !y_sts.ready)
        else $error("axis mapper not busy after start");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid_reg |-> (frame_touch_reg ? (idx_reg <= BYTE_Y_LO)
                                             : (idx_reg <= BYTE_SCAN)))
        else $error("frame byte index past end of frame");

    a_frame_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_out && last_byte && !slot_move) |=> empty)
        else $error("frame register still full after last byte");
`endif

endmodule
